>>> hdl/vtb_pkg.sv
// Package for the vario tone and beep controller: codes, widths, config type and constants.
package vtb_pkg;

  localparam int VARIO_W = 14;
  localparam int VAL_W   = 15;
  localparam int TICK_W  = 16;
  localparam int VOL_W   = 7;
  localparam int IDX_W   = 6;

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_WRITE  = 2'd2;

  localparam logic [1:0] SEL_FREQ   = 2'd0;
  localparam logic [1:0] SEL_LENGTH = 2'd1;
  localparam logic [1:0] SEL_PAUSE  = 2'd2;

  localparam logic [1:0] REG_LIFT   = 2'd0;
  localparam logic [1:0] REG_SINK   = 2'd1;
  localparam logic [1:0] REG_VOLUME = 2'd2;
  localparam logic [1:0] REG_FLUID  = 2'd3;

  localparam int APB_ADDR_W = 4;

  // climb rate biased to a non-negative multiple-of-50 offset: 8200 = 50 * 164
  localparam int VARIO_BIAS = 8200;
  localparam int Q_BIAS     = 164;
  localparam int RECIP50    = 20972;   // ceil(2^20 / 50)
  localparam int RECIP50_SH = 20;
  localparam int RECIP10    = 419431;  // ceil(2^22 / 10)
  localparam int RECIP10_SH = 22;
  localparam int TENTHS_MAX = 10;

  typedef struct packed {
    logic signed [VARIO_W-1:0] lift_threshold;
    logic signed [VARIO_W-1:0] sink_threshold;
    logic        [VOL_W-1:0]   volume;
    logic                      fluid_update;
  } cfg_t;

endpackage

>>> hdl/vtb_if.sv
// Request and result channel interfaces of the vario tone and beep controller.
interface vtb_in_if;
  import vtb_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic signed [VARIO_W-1:0] vario_cms;
  logic [1:0]                table_select;
  logic [IDX_W-1:0]          table_index;
  logic [VAL_W-1:0]          table_value;

  modport source (output valid, req_type, vario_cms, table_select, table_index,
                  table_value, input ready);
  modport sink (input valid, req_type, vario_cms, table_select, table_index,
                table_value, output ready);
endinterface

interface vtb_out_if;
  import vtb_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] tone_freq;
  logic [VOL_W-1:0] tone_volume;
  logic             beep_running;
  logic             in_pause;

  modport source (output valid, tone_freq, tone_volume, beep_running, in_pause,
                  input ready);
  modport sink (input valid, tone_freq, tone_volume, beep_running, in_pause,
                output ready);
endinterface

>>> hdl/vario_tone_beep_controller.sv
// Vario tone and beep controller top level: request pipeline, curve tables and beep timer.
// Takes one request per clock unless the result side stalls; each request (climb-rate
// sample, timer tick or table write) gives exactly one result, the buzzer drive state after
// that request. Pipeline stages: reciprocal divide by 50, table address and registered RAM
// read, interpolation numerator, reciprocal divide by 10, then the timer/drive state update
// into the output register. A stall on the result side holds the whole pipeline.
// The three curve tables are RAMs with no reset; entries must be written before use.
module vario_tone_beep_controller #(
  parameter int TABLE_ENTRIES = 41
) (
  input  logic                           clk,
  input  logic                           rst,
  vtb_in_if.sink                         req,
  vtb_out_if.source                      rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vtb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import vtb_pkg::*;

  localparam int AW     = $clog2(TABLE_ENTRIES);
  localparam int CENTER = (TABLE_ENTRIES - 1) / 2;
  localparam logic signed [11:0] IDX_OFS = 12'(CENTER - Q_BIAS);
  localparam logic signed [11:0] LAST_S  = 12'(TABLE_ENTRIES - 2);
  localparam logic [AW-1:0]      LAST_A  = AW'(TABLE_ENTRIES - 2);

  cfg_t cfg;
  logic adv;

  vtb_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  // stage valids
  logic v1, v2, v3, v4, v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      rsp.valid <= 1'b0;
    end else if (adv) begin
      v1 <= req.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      rsp.valid <= v5;
    end
  end

  // stage 1: input register
  logic [1:0]                s1_req;
  logic signed [VARIO_W-1:0] s1_v;
  logic [1:0]                s1_sel;
  logic [IDX_W-1:0]          s1_index;
  logic [VAL_W-1:0]          s1_value;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_req   <= req.req_type;
      s1_v     <= req.vario_cms;
      s1_sel   <= req.table_select;
      s1_index <= req.table_index;
      s1_value <= req.table_value;
    end
  end

  logic [14:0] s1_w;
  logic [29:0] s1_prod;
  logic        s1_lift, s1_sink, s1_idx_ok;

  assign s1_w      = 15'({s1_v[VARIO_W-1], s1_v}) + 15'(VARIO_BIAS);
  assign s1_prod   = 30'(s1_w) * 30'(RECIP50);
  assign s1_lift   = s1_v >= cfg.lift_threshold;
  assign s1_sink   = s1_v <= cfg.sink_threshold;
  assign s1_idx_ok = int'(s1_index) < TABLE_ENTRIES;

  // stage 2: quotient by 50 known
  logic [1:0]       s2_req;
  logic [14:0]      s2_w;
  logic [8:0]       s2_q;
  logic             s2_active, s2_lift, s2_idx_ok;
  logic [1:0]       s2_sel;
  logic [IDX_W-1:0] s2_index;
  logic [VAL_W-1:0] s2_value;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_req    <= s1_req;
      s2_w      <= s1_w;
      s2_q      <= s1_prod[RECIP50_SH+8:RECIP50_SH];
      s2_active <= (s1_lift || s1_sink) && (cfg.volume != '0);
      s2_lift   <= s1_lift;
      s2_idx_ok <= s1_idx_ok;
      s2_sel    <= s1_sel;
      s2_index  <= s1_index;
      s2_value  <= s1_value;
    end
  end

  logic [14:0]        s2_q50, s2_rem;
  logic [5:0]         s2_r;
  logic [9:0]         s2_rp, s2_tm;
  logic [3:0]         s2_t_raw, s2_t;
  logic signed [11:0] s2_idx;
  logic [AW-1:0]      s2_ra, s2_rb, s2_waddr;
  logic               s2_wr;

  always_comb begin
    s2_q50   = 15'({s2_q, 5'b0}) + 15'({s2_q, 4'b0}) + 15'({s2_q, 1'b0});
    s2_rem   = s2_w - s2_q50;
    s2_r     = s2_rem[5:0];
    s2_rp    = {4'b0, s2_r} + 10'd2;
    s2_tm    = s2_rp * 10'd13;
    s2_t_raw = s2_tm[9:6];
    s2_idx   = $signed({3'b0, s2_q}) + IDX_OFS;
    if (s2_idx > LAST_S) begin
      s2_ra = LAST_A;
      s2_t  = 4'(TENTHS_MAX);
    end else if (s2_idx < 12'sd0) begin
      s2_ra = '0;
      s2_t  = 4'd0;
    end else begin
      s2_ra = s2_idx[AW-1:0];
      s2_t  = s2_t_raw;
    end
    s2_rb = s2_ra + AW'(1);
  end

  assign s2_wr    = adv && v2 && (s2_req == REQ_WRITE) && s2_idx_ok;
  assign s2_waddr = AW'(s2_index);

  // stage 3: table entries read
  logic [1:0]       s3_req;
  logic             s3_active, s3_lift;
  logic [3:0]       s3_t;
  logic [VAL_W-1:0] fa, fb, la, lb, pa, pb;

  vtb_table #(.ENTRIES(TABLE_ENTRIES)) u_freq (
    .clk, .we(s2_wr && (s2_sel == SEL_FREQ)), .waddr(s2_waddr), .wdata(s2_value),
    .re(adv), .raddr_a(s2_ra), .raddr_b(s2_rb), .rdata_a(fa), .rdata_b(fb)
  );

  vtb_table #(.ENTRIES(TABLE_ENTRIES)) u_length (
    .clk, .we(s2_wr && (s2_sel == SEL_LENGTH)), .waddr(s2_waddr), .wdata(s2_value),
    .re(adv), .raddr_a(s2_ra), .raddr_b(s2_rb), .rdata_a(la), .rdata_b(lb)
  );

  vtb_table #(.ENTRIES(TABLE_ENTRIES)) u_pause (
    .clk, .we(s2_wr && (s2_sel == SEL_PAUSE)), .waddr(s2_waddr), .wdata(s2_value),
    .re(adv), .raddr_a(s2_ra), .raddr_b(s2_rb), .rdata_a(pa), .rdata_b(pb)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_req    <= s2_req;
      s3_active <= s2_active;
      s3_lift   <= s2_lift;
      s3_t      <= s2_t;
    end
  end

  // 10*a + (b - a)*t, never negative
  function automatic logic [18:0] interp_num(input logic [VAL_W-1:0] a,
                                             input logic [VAL_W-1:0] b,
                                             input logic [3:0] t);
    logic signed [15:0] d;
    logic signed [20:0] dt;
    logic [18:0]        a10;
    logic signed [20:0] n;
    d   = $signed({1'b0, b}) - $signed({1'b0, a});
    dt  = d * $signed({1'b0, t});
    a10 = 19'({a, 3'b0}) + 19'({a, 1'b0});
    n   = $signed({2'b0, a10}) + dt;
    return n[18:0];
  endfunction

  function automatic logic [VAL_W-1:0] div10(input logic [18:0] n);
    logic [37:0] p;
    p = 38'(n) * 38'(RECIP10);
    return p[RECIP10_SH+VAL_W-1:RECIP10_SH];
  endfunction

  // stage 4: numerators
  logic [1:0]  s4_req;
  logic        s4_active, s4_lift;
  logic [18:0] s4_fn, s4_ln, s4_pn;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_req    <= s3_req;
      s4_active <= s3_active;
      s4_lift   <= s3_lift;
      s4_fn     <= interp_num(fa, fb, s3_t);
      s4_ln     <= interp_num(la, lb, s3_t);
      s4_pn     <= interp_num(pa, pb, s3_t);
    end
  end

  // stage 5: interpolated values
  logic [1:0]       s5_req;
  logic             s5_active, s5_lift;
  logic [VAL_W-1:0] s5_f, s5_len, s5_pau;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_req    <= s4_req;
      s5_active <= s4_active;
      s5_lift   <= s4_lift;
      s5_f      <= div10(s4_fn);
      s5_len    <= div10(s4_ln);
      s5_pau    <= div10(s4_pn);
    end
  end

  // timer and drive state
  logic [VAL_W-1:0]  pending_tone, pending_tone_next;
  logic [TICK_W-1:0] pending_sound_ticks, pending_sound_ticks_next;
  logic [TICK_W-1:0] pending_pause_ticks, pending_pause_ticks_next;
  logic              beeping_mode, beeping_mode_next;
  logic              pause_phase, pause_phase_next;
  logic              timer_on, timer_on_next;
  logic [TICK_W-1:0] tick_count, tick_count_next;
  logic [TICK_W-1:0] tick_top, tick_top_next;
  logic [VAL_W-1:0]  drive_freq, drive_freq_next;
  logic [VOL_W-1:0]  drive_volume, drive_volume_next;

  function automatic logic [TICK_W-1:0] times31(input logic [VAL_W-1:0] x);
    logic [20:0] s;
    s = {1'b0, x, 5'b0} - {6'b0, x};
    return s[TICK_W-1:0];
  endfunction

  always_comb begin
    logic [VAL_W-1:0] f, len, pau;
    f   = s5_active ? s5_f : '0;
    len = (s5_active && s5_lift) ? s5_len : '0;
    pau = (s5_active && s5_lift) ? s5_pau : '0;
    pending_tone_next        = pending_tone;
    pending_sound_ticks_next = pending_sound_ticks;
    pending_pause_ticks_next = pending_pause_ticks;
    beeping_mode_next        = beeping_mode;
    pause_phase_next         = pause_phase;
    timer_on_next            = timer_on;
    tick_count_next          = tick_count;
    tick_top_next            = tick_top;
    drive_freq_next          = drive_freq;
    drive_volume_next        = drive_volume;
    case (s5_req)
      REQ_SAMPLE: begin
        if (f == '0) begin
          pending_tone_next = '0;
          if (!beeping_mode) drive_volume_next = '0;
        end else begin
          pending_tone_next = f;
          if (!beeping_mode) begin
            drive_freq_next   = f;
            drive_volume_next = cfg.volume;
          end
          if (cfg.fluid_update && !pause_phase) drive_freq_next = f;
        end
        if (len == '0 || pau == '0) begin
          pending_sound_ticks_next = '0;
          pending_pause_ticks_next = '0;
        end else begin
          pending_sound_ticks_next = times31(len);
          pending_pause_ticks_next = times31(pau);
          if (!beeping_mode) begin
            tick_count_next   = TICK_W'(1);
            drive_freq_next   = pending_tone_next;
            drive_volume_next = cfg.volume;
            tick_top_next     = pending_sound_ticks_next;
            timer_on_next     = 1'b1;
            pause_phase_next  = 1'b0;
          end
          beeping_mode_next = 1'b1;
        end
      end
      REQ_TICK: begin
        if (timer_on) begin
          if (tick_count == tick_top) begin
            tick_count_next = '0;
            if (!pause_phase) begin
              drive_volume_next = '0;
              if (pending_pause_ticks == '0) begin
                timer_on_next     = 1'b0;
                beeping_mode_next = 1'b0;
              end else begin
                tick_top_next    = pending_pause_ticks;
                pause_phase_next = 1'b1;
              end
            end else begin
              if (pending_tone != '0) begin
                drive_freq_next   = pending_tone;
                drive_volume_next = cfg.volume;
              end
              if (pending_sound_ticks == '0) begin
                timer_on_next     = 1'b0;
                beeping_mode_next = 1'b0;
              end else begin
                tick_top_next    = pending_sound_ticks;
                pause_phase_next = 1'b0;
              end
            end
          end else begin
            tick_count_next = tick_count + TICK_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_tone        <= '0;
      pending_sound_ticks <= '0;
      pending_pause_ticks <= '0;
      beeping_mode        <= 1'b0;
      pause_phase         <= 1'b0;
      timer_on            <= 1'b0;
      tick_count          <= '0;
      tick_top            <= '0;
      drive_freq          <= '0;
      drive_volume        <= '0;
    end else if (adv && v5) begin
      pending_tone        <= pending_tone_next;
      pending_sound_ticks <= pending_sound_ticks_next;
      pending_pause_ticks <= pending_pause_ticks_next;
      beeping_mode        <= beeping_mode_next;
      pause_phase         <= pause_phase_next;
      timer_on            <= timer_on_next;
      tick_count          <= tick_count_next;
      tick_top            <= tick_top_next;
      drive_freq          <= drive_freq_next;
      drive_volume        <= drive_volume_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v5) begin
      rsp.tone_freq    <= drive_freq_next;
      rsp.tone_volume  <= drive_volume_next;
      rsp.beep_running <= timer_on_next;
      rsp.in_pause     <= pause_phase_next;
    end
  end

endmodule

>>> hdl/vtb_cfg.sv
// APB configuration registers of the vario tone and beep controller.
module vtb_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vtb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output vtb_pkg::cfg_t                  cfg
);
  import vtb_pkg::*;

  logic       wr;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lift_threshold <= 14'sd10;
      cfg.sink_threshold <= -14'sd200;
      cfg.volume         <= 7'd50;
      cfg.fluid_update   <= 1'b0;
    end else if (wr) begin
      case (reg_sel)
        REG_LIFT:   cfg.lift_threshold <= pwdata[VARIO_W-1:0];
        REG_SINK:   cfg.sink_threshold <= pwdata[VARIO_W-1:0];
        REG_VOLUME: cfg.volume         <= pwdata[VOL_W-1:0];
        REG_FLUID:  cfg.fluid_update   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_LIFT:   prdata = 32'(cfg.lift_threshold);
      REG_SINK:   prdata = 32'(cfg.sink_threshold);
      REG_VOLUME: prdata = {25'b0, cfg.volume};
      REG_FLUID:  prdata = {31'b0, cfg.fluid_update};
      default:    prdata = 32'b0;
    endcase
  end

endmodule

>>> hdl/vtb_table.sv
// Curve table RAM: one write port, two registered read ports.
module vtb_table #(
  parameter int ENTRIES = 41,
  localparam int AW = $clog2(ENTRIES)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [vtb_pkg::VAL_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr_a,
  input  logic [AW-1:0]             raddr_b,
  output logic [vtb_pkg::VAL_W-1:0] rdata_a,
  output logic [vtb_pkg::VAL_W-1:0] rdata_b
);
  import vtb_pkg::*;

  logic [VAL_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> hdl/vtb_checker.sv
// Port-level checks for the vario tone and beep controller, bound to the top level.
module vtb_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [vtb_pkg::VAL_W-1:0] tone_freq,
  input logic [vtb_pkg::VOL_W-1:0] tone_volume,
  input logic                      beep_running,
  input logic                      in_pause
);
  import vtb_pkg::*;

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("pipeline not empty after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(tone_freq) &&
      $stable(tone_volume) && $stable(beep_running) && $stable(in_pause))
    else $error("stalled result changed");

  a_stall_backpressure: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request taken while result stalled");

  a_pause_silent: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && beep_running && in_pause |-> tone_volume == '0)
    else $error("buzzer sounding during pause");

endmodule

bind vario_tone_beep_controller vtb_checker u_vtb_checker (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .tone_freq    (rsp.tone_freq),
  .tone_volume  (rsp.tone_volume),
  .beep_running (rsp.beep_running),
  .in_pause     (rsp.in_pause)
);
